// ----- rtl/opi_pkg.sv -----
// Package for the odometry pose integrator: constants, arctangent table, saturation helpers.
`timescale 1ns / 1ps

package opi_pkg;

  // Default parameter values
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int ROTATE_STEPS_DEF = 16;

  // CORDIC gain compensation, 0.6072529... scaled by 2^32
  localparam logic [31:0] GAIN_K = 32'd2608131496;

  // Guard bits carried through the rotation
  localparam int GUARD_BITS = 8;

  // Rotation datapath width: 32-bit value, guard bits, growth headroom
  localparam int CX_W = 42;

  // Arctangent table, 2^32 units per turn
  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:    val = 32'sd536870912;
      5'd1:    val = 32'sd316933406;
      5'd2:    val = 32'sd167458907;
      5'd3:    val = 32'sd85004756;
      5'd4:    val = 32'sd42667331;
      5'd5:    val = 32'sd21354465;
      5'd6:    val = 32'sd10679838;
      5'd7:    val = 32'sd5340245;
      5'd8:    val = 32'sd2670163;
      5'd9:    val = 32'sd1335087;
      5'd10:   val = 32'sd667544;
      5'd11:   val = 32'sd333772;
      5'd12:   val = 32'sd166886;
      5'd13:   val = 32'sd83443;
      5'd14:   val = 32'sd41721;
      5'd15:   val = 32'sd20861;
      5'd16:   val = 32'sd10430;
      5'd17:   val = 32'sd5215;
      5'd18:   val = 32'sd2608;
      5'd19:   val = 32'sd1304;
      5'd20:   val = 32'sd652;
      5'd21:   val = 32'sd326;
      5'd22:   val = 32'sd163;
      5'd23:   val = 32'sd81;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

  // Clamp a signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat_s32(input logic signed [34:0] v);
    logic signed [31:0] res;
    if (v > 35'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // Clamp an unsigned 33-bit sum to 32 bits
  function automatic logic [31:0] sat_u32(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ----- rtl/odometry_pose_integrator.sv -----
// Odometry pose integrator: SE(2) accumulation of odometry increments with CORDIC rotation.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------------
//   in      | in        | in_valid/in_ready  | op, step_x/y/turn, var_*, covar_*, stop_time
//   out     | out       | out_valid/out_ready| pose_*, acc_var_*, acc_covar_*, last_time
//
// Integrate (op 0): from one transfer to the next possible one the sequencer runs MUL_X and
// MUL_Y on the shared gain multiplier, QUAD for the quarter turn, ROT on the shared CORDIC
// step unit until the last rotation step, FIN to accumulate, then IDLE.
// Restart (op 1): IDLE goes straight to FIN, the rotation is skipped.
// Reset clears the pose, covariance and end time to zero and the sequencer to idle.
// The accumulate cycle waits while an earlier result is still untaken on out.
`timescale 1ns / 1ps

module odometry_pose_integrator #(
  parameter int ANGLE_BITS   = opi_pkg::ANGLE_BITS_DEF,
  parameter int ROTATE_STEPS = opi_pkg::ROTATE_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [0:0]         op,
  input  logic signed [31:0] step_x,
  input  logic signed [31:0] step_y,
  input  logic signed [15:0] step_turn,
  input  logic [31:0]        var_x,
  input  logic signed [31:0] covar_xy,
  input  logic signed [31:0] covar_xh,
  input  logic [31:0]        var_y,
  input  logic signed [31:0] covar_yh,
  input  logic [31:0]        var_h,
  input  logic [31:0]        stop_time,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [15:0] pose_heading,
  output logic [31:0]        acc_var_x,
  output logic signed [31:0] acc_covar_xy,
  output logic signed [31:0] acc_covar_xh,
  output logic [31:0]        acc_var_y,
  output logic signed [31:0] acc_covar_yh,
  output logic [31:0]        acc_var_h,
  output logic [31:0]        last_time
);

  import opi_pkg::*;

  localparam int CNT_W = (ROTATE_STEPS > 1) ? $clog2(ROTATE_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROTATE_STEPS - 1);
  localparam int SIGN_PAD = CX_W - 32 - GUARD_BITS;
  localparam logic signed [CX_W-1:0] ROUND_HALF = CX_W'(1 << (GUARD_BITS - 1));
  localparam logic signed [64:0] PROD_ROUND = 65'sd2147483648;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_X = 3'd1;
  localparam logic [2:0] ST_MUL_Y = 3'd2;
  localparam logic [2:0] ST_QUAD  = 3'd3;
  localparam logic [2:0] ST_ROT   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [CNT_W-1:0]        step_cnt;

  // Captured item
  logic                    cur_op;
  logic signed [31:0]      cur_x;
  logic signed [31:0]      cur_y;
  logic [ANGLE_BITS-1:0]   cur_turn;
  logic [31:0]             cur_vx;
  logic [31:0]             cur_vy;
  logic [31:0]             cur_vh;
  logic signed [31:0]      cur_cxy;
  logic signed [31:0]      cur_cxh;
  logic signed [31:0]      cur_cyh;
  logic [31:0]             cur_time;

  // Accumulated state
  logic signed [31:0]      sum_x;
  logic signed [31:0]      sum_y;
  logic [ANGLE_BITS-1:0]   sum_heading;
  logic [31:0]             sum_var_x;
  logic [31:0]             sum_var_y;
  logic [31:0]             sum_var_h;
  logic signed [31:0]      sum_cxy;
  logic signed [31:0]      sum_cxh;
  logic signed [31:0]      sum_cyh;
  logic [31:0]             span_end;

  // Rotation datapath
  logic signed [64:0]      prod;
  logic signed [31:0]      gx;
  logic signed [CX_W-1:0]  cx;
  logic signed [CX_W-1:0]  cy;
  logic signed [31:0]      r_ang;

  logic                    in_xfer;
  logic                    out_free;
  logic signed [31:0]      turn_wide;
  logic signed [31:0]      mul_a;
  logic signed [32:0]      gain_op;
  logic signed [64:0]      prod_full;
  logic signed [64:0]      prod_rnd;
  logic signed [31:0]      gy;
  logic [31:0]             z_ang;
  logic [31:0]             z_bias;
  logic [1:0]              quad;
  logic signed [31:0]      resid;
  logic signed [31:0]      qx;
  logic signed [31:0]      qy;
  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;
  logic signed [31:0]      atan_val;
  logic signed [CX_W-1:0]  rnd_x;
  logic signed [CX_W-1:0]  rnd_y;
  logic signed [34:0]      pos_x_sum;
  logic signed [34:0]      pos_y_sum;
  logic [31:0]             heading_wide;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign turn_wide = 32'(step_turn);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = op[0] ? ST_FIN : ST_MUL_X;
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_QUAD;
      ST_QUAD:  state_next = ST_ROT;
      ST_ROT:   if (step_cnt == LAST_STEP) state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ROT) begin
        step_cnt <= step_cnt + CNT_W'(1);
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_op   <= op[0];
      cur_x    <= step_x;
      cur_y    <= step_y;
      cur_turn <= turn_wide[ANGLE_BITS-1:0];
      cur_vx   <= var_x;
      cur_vy   <= var_y;
      cur_vh   <= var_h;
      cur_cxy  <= covar_xy;
      cur_cxh  <= covar_xh;
      cur_cyh  <= covar_yh;
      cur_time <= stop_time;
    end
  end

  // Shared gain multiplier, x then y
  assign mul_a     = (state == ST_MUL_X) ? cur_x : cur_y;
  assign gain_op   = $signed({1'b0, GAIN_K});
  assign prod_full = mul_a * gain_op;
  assign prod_rnd  = prod + PROD_ROUND;
  assign gy        = prod_rnd[63:32];

  // Quarter-turn split of the stored heading
  assign z_ang  = {sum_heading, {(32 - ANGLE_BITS){1'b0}}};
  assign z_bias = z_ang + 32'h2000_0000;
  assign quad   = z_bias[31:30];
  assign resid  = $signed(z_ang - {quad, 30'd0});

  always_comb begin
    case (quad)
      2'd0:    begin qx = gx;  qy = gy;  end
      2'd1:    begin qx = -gy; qy = gx;  end
      2'd2:    begin qx = -gx; qy = -gy; end
      default: begin qx = gy;  qy = -gx; end
    endcase
  end

  // CORDIC step unit
  assign dx       = cy >>> step_cnt;
  assign dy       = cx >>> step_cnt;
  assign atan_val = atan_entry(5'(step_cnt));

  always_ff @(posedge clk) begin
    if (state == ST_MUL_X || state == ST_MUL_Y) begin
      prod <= prod_full;
    end
    if (state == ST_MUL_Y) begin
      gx <= prod_rnd[63:32];
    end
    if (state == ST_QUAD) begin
      cx    <= {{SIGN_PAD{qx[31]}}, qx, {GUARD_BITS{1'b0}}};
      cy    <= {{SIGN_PAD{qy[31]}}, qy, {GUARD_BITS{1'b0}}};
      r_ang <= resid;
    end else if (state == ST_ROT) begin
      if (!r_ang[31]) begin
        cx    <= cx - dx;
        cy    <= cy + dy;
        r_ang <= r_ang - atan_val;
      end else begin
        cx    <= cx + dx;
        cy    <= cy - dy;
        r_ang <= r_ang + atan_val;
      end
    end
  end

  // Drop guard bits with round half up, then add to the position
  assign rnd_x     = cx + ROUND_HALF;
  assign rnd_y     = cy + ROUND_HALF;
  assign pos_x_sum = 35'(sum_x) + 35'($signed(rnd_x[CX_W-1:GUARD_BITS]));
  assign pos_y_sum = 35'(sum_y) + 35'($signed(rnd_y[CX_W-1:GUARD_BITS]));

  // Accumulate or restart, and post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x       <= '0;
      sum_y       <= '0;
      sum_heading <= '0;
      sum_var_x   <= '0;
      sum_var_y   <= '0;
      sum_var_h   <= '0;
      sum_cxy     <= '0;
      sum_cxh     <= '0;
      sum_cyh     <= '0;
      span_end    <= '0;
      out_valid   <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      if (cur_op) begin
        sum_x       <= cur_x;
        sum_y       <= cur_y;
        sum_heading <= cur_turn;
        sum_var_x   <= cur_vx;
        sum_var_y   <= cur_vy;
        sum_var_h   <= cur_vh;
        sum_cxy     <= cur_cxy;
        sum_cxh     <= cur_cxh;
        sum_cyh     <= cur_cyh;
      end else begin
        sum_x       <= sat_s32(pos_x_sum);
        sum_y       <= sat_s32(pos_y_sum);
        sum_heading <= sum_heading + cur_turn;
        sum_var_x   <= sat_u32({1'b0, sum_var_x} + {1'b0, cur_vx});
        sum_var_y   <= sat_u32({1'b0, sum_var_y} + {1'b0, cur_vy});
        sum_var_h   <= sat_u32({1'b0, sum_var_h} + {1'b0, cur_vh});
        sum_cxy     <= sat_s32(35'(sum_cxy) + 35'(cur_cxy));
        sum_cxh     <= sat_s32(35'(sum_cxh) + 35'(cur_cxh));
        sum_cyh     <= sat_s32(35'(sum_cyh) + 35'(cur_cyh));
      end
      span_end  <= cur_time;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result fields read straight from the accumulated state
  assign heading_wide = 32'(sum_heading);
  assign pose_x       = sum_x;
  assign pose_y       = sum_y;
  assign pose_heading = heading_wide[15:0];
  assign acc_var_x    = sum_var_x;
  assign acc_var_y    = sum_var_y;
  assign acc_var_h    = sum_var_h;
  assign acc_covar_xy = sum_cxy;
  assign acc_covar_xh = sum_cxh;
  assign acc_covar_yh = sum_cyh;
  assign last_time    = span_end;

  // Checks
  a_restart_skips_rotation: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op[0]) |=> (state == ST_FIN))
    else $error("restart item did not go straight to accumulate");

  a_integrate_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !op[0]) |=> (state == ST_MUL_X))
    else $error("integrate item did not start on the multiplier");

  a_rotation_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROT && step_cnt == LAST_STEP) |=> (state == ST_FIN))
    else $error("rotation did not end after the last step");

  a_fin_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && !out_ready) |=> (state == ST_FIN && out_valid))
    else $error("accumulate ran over an untaken result");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result posted outside the accumulate cycle");

endmodule
